[rtl/cli_pkg.sv]
package cli_pkg;

	localparam int unsigned LEVELS_DEF = 64;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned DCNT_W     = $clog2(FRAC_W);

	// operation codes
	localparam logic [1:0] OP_WR_H  = 2'd0;
	localparam logic [1:0] OP_WR_S  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// position codes
	localparam logic [1:0] POS_IN  = 2'd0;
	localparam logic [1:0] POS_BOT = 2'd1;
	localparam logic [1:0] POS_TOP = 2'd2;

	// table read address select
	localparam logic [2:0] RD_TOP = 3'd0;
	localparam logic [2:0] RD_BOT = 3'd1;
	localparam logic [2:0] RD_MID = 3'd2;
	localparam logic [2:0] RD_LO  = 3'd3;
	localparam logic [2:0] RD_LO1 = 3'd4;

	typedef struct packed {
		logic       wr_h;
		logic       wr_s;
		logic       ld_z;
		logic       rd_en;
		logic [2:0] rd_sel;
		logic       srch_init;
		logic       srch_step;
		logic       ld_p0;
		logic       ld_p1;
		logic       div_setup;
		logic       div_step;
		logic       mul;
		logic       rnd;
		logic       res_ld;
		logic [1:0] res_pos;
		logic       out_ld;
	} cli_cmd_t;

	typedef struct packed {
		logic z_ge_h;
		logic z_le_h;
		logic srch_done;
		logic frac_zero;
		logic frac_sat;
	} cli_sts_t;

endpackage

[rtl/column_linear_interpolator.sv]
// Column linear interpolator: holds up to MAX_LEVELS strictly increasing level
// heights and one sample per level (signed Q16.16), loaded one request at a
// time (operation 0 height, 1 sample, 2 query; 3 is dropped). A query returns the
// sample at the given height by linear interpolation, clamped to the first or last
// sample at or beyond the table ends, with position telling which case applied.
// A query clamped at the top is resolved with one table read, at the bottom with
// two; an interior query runs a binary search through the single read port of
// each table and a 16-bit one-bit-per-cycle fraction divider; when the fraction
// is zero or saturated the divider is skipped. One query is processed at a time;
// the next request is taken while the previous result waits in the output
// register. The user must write active_levels (reset 64, limited to
// 2..MAX_LEVELS) only while the block is idle; the block does not enforce this.
module column_linear_interpolator #(
	parameter int unsigned MAX_LEVELS = cli_pkg::LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [6:0]         cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [5:0]         slot,
	input  logic signed [31:0] word,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] interpolated,
	output logic [1:0]         position
);
	import cli_pkg::*;

	cli_cmd_t cmd;
	cli_sts_t sts;

	cli_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cli_datapath #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.slot         (slot),
		.word         (word),
		.cmd          (cmd),
		.sts          (sts),
		.interpolated (interpolated),
		.position     (position)
	);

endmodule

[rtl/cli_datapath.sv]
module cli_datapath #(
	parameter int unsigned MAX_LEVELS = cli_pkg::LEVELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [6:0]            cfg_wr_data,
	input  logic [5:0]            slot,
	input  logic signed [31:0]    word,
	input  cli_pkg::cli_cmd_t     cmd,
	output cli_pkg::cli_sts_t     sts,
	output logic signed [31:0]    interpolated,
	output logic [1:0]            position
);
	import cli_pkg::*;

	localparam int unsigned AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int unsigned NW = $clog2(MAX_LEVELS + 1);
	localparam int unsigned CW = (NW > 7) ? NW : 7;

	logic [6:0]              active_levels_q;
	logic [DATA_W-1:0]       mem_h [MAX_LEVELS];
	logic [DATA_W-1:0]       mem_s [MAX_LEVELS];
	logic signed [31:0]      rd_h_q, rd_s_q, z_q, h0_q, s0_q;
	logic [AW-1:0]           lo_q, hi_q;
	logic signed [32:0]      num_q, den_q, diff_q;
	logic [31:0]             rem_q;
	logic [FRAC_W-1:0]       quo_q;
	logic signed [49:0]      prod_q;
	logic signed [33:0]      rnd_q;
	logic signed [31:0]      res_q;
	logic [1:0]              pos_q;

	logic [CW-1:0]           n_raw, n_lim;
	logic [AW-1:0]           top_idx, mid, lo_p1, rd_addr, wr_addr;
	logic [AW:0]             lohi_sum;
	logic                    slot_ok;
	logic [32:0]             sh;
	logic [33:0]             trial;
	logic signed [49:0]      prod_b;
	logic signed [34:0]      sum35;
	logic signed [31:0]      sat_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_levels_q <= 7'(LEVELS_DEF);
		end else if (cfg_wr_en) begin
			active_levels_q <= cfg_wr_data;
		end
	end

	// level count limited to 2..MAX_LEVELS
	always_comb begin
		n_raw = CW'(active_levels_q);
		if (n_raw < CW'(2))
			n_lim = CW'(2);
		else if (n_raw > CW'(MAX_LEVELS))
			n_lim = CW'(MAX_LEVELS);
		else
			n_lim = n_raw;
	end

	assign top_idx  = AW'(n_lim - CW'(1));
	assign lohi_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = lohi_sum[AW:1];
	assign lo_p1    = lo_q + AW'(1);
	assign slot_ok  = 32'(slot) < 32'(MAX_LEVELS);
	assign wr_addr  = AW'(slot);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_TOP: rd_addr = top_idx;
			RD_BOT: rd_addr = '0;
			RD_MID: rd_addr = mid;
			RD_LO:  rd_addr = lo_q;
			RD_LO1: rd_addr = lo_p1;
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_h && slot_ok)
			mem_h[wr_addr] <= word;
		if (cmd.wr_s && slot_ok)
			mem_s[wr_addr] <= word;
		if (cmd.rd_en) begin
			rd_h_q <= mem_h[rd_addr];
			rd_s_q <= mem_s[rd_addr];
		end
	end

	assign sts.z_ge_h    = z_q >= rd_h_q;
	assign sts.z_le_h    = z_q <= rd_h_q;
	assign sts.srch_done = {1'b0, hi_q} <= ({1'b0, lo_q} + (AW+1)'(1));
	assign sts.frac_zero = num_q[32] || den_q[32] || (den_q == '0);
	assign sts.frac_sat  = num_q >= den_q;

	// one quotient bit per step; remainder stays below the divisor
	assign sh    = {rem_q, 1'b0};
	assign trial = {1'b0, sh} - {2'b00, den_q[31:0]};

	assign prod_b = prod_q + 50'sd32768;
	assign sum35  = 35'(s0_q) + 35'(rnd_q);

	always_comb begin
		if (sum35[34:31] == 4'b0000 || sum35[34:31] == 4'b1111)
			sat_val = sum35[31:0];
		else if (sum35[34])
			sat_val = 32'sh8000_0000;
		else
			sat_val = 32'sh7FFF_FFFF;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_z)
			z_q <= word;
		if (cmd.srch_init) begin
			lo_q <= '0;
			hi_q <= top_idx;
		end else if (cmd.srch_step) begin
			if (rd_h_q > z_q)
				hi_q <= mid;
			else
				lo_q <= mid;
		end
		if (cmd.ld_p0) begin
			h0_q <= rd_h_q;
			s0_q <= rd_s_q;
		end
		if (cmd.ld_p1) begin
			num_q  <= 33'(z_q) - 33'(h0_q);
			den_q  <= 33'(rd_h_q) - 33'(h0_q);
			diff_q <= 33'(rd_s_q) - 33'(s0_q);
		end
		if (cmd.div_setup) begin
			rem_q <= num_q[31:0];
			if (!sts.frac_zero && sts.frac_sat)
				quo_q <= '1;
			else
				quo_q <= '0;
		end else if (cmd.div_step) begin
			if (!trial[33]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[FRAC_W-2:0], 1'b1};
			end else begin
				rem_q <= sh[31:0];
				quo_q <= {quo_q[FRAC_W-2:0], 1'b0};
			end
		end
		if (cmd.mul)
			prod_q <= $signed({1'b0, quo_q}) * diff_q;
		if (cmd.rnd)
			rnd_q <= prod_b[49:16];
		if (cmd.res_ld) begin
			pos_q <= cmd.res_pos;
			if (cmd.res_pos == POS_IN)
				res_q <= sat_val;
			else
				res_q <= rd_s_q;
		end
		if (cmd.out_ld) begin
			interpolated <= res_q;
			position     <= pos_q;
		end
	end

endmodule

[rtl/cli_controller.sv]
module cli_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        operation,
	output logic              out_valid,
	input  logic              out_stall,
	input  cli_pkg::cli_sts_t sts,
	output cli_pkg::cli_cmd_t cmd
);
	import cli_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TOP  = 4'd1;
	localparam logic [3:0] S_BOT  = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_CMP  = 4'd4;
	localparam logic [3:0] S_LD0  = 4'd5;
	localparam logic [3:0] S_LD1  = 4'd6;
	localparam logic [3:0] S_DCHK = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_MUL  = 4'd9;
	localparam logic [3:0] S_RND  = 4'd10;
	localparam logic [3:0] S_ADD  = 4'd11;
	localparam logic [3:0] S_FIN  = 4'd12;

	logic [3:0]        state_q, state_nx;
	logic [DCNT_W-1:0] cnt_q;
	logic              out_valid_q;
	logic              accept;

	assign in_stall  = state_q != S_IDLE;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = RD_TOP;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (operation)
						OP_WR_H: cmd.wr_h = 1'b1;
						OP_WR_S: cmd.wr_s = 1'b1;
						OP_QUERY: begin
							cmd.ld_z   = 1'b1;
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_TOP;
							state_nx   = S_TOP;
						end
						default: ;
					endcase
				end
			end
			S_TOP: begin
				if (sts.z_ge_h) begin
					cmd.res_ld  = 1'b1;
					cmd.res_pos = POS_TOP;
					state_nx    = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_BOT;
					state_nx   = S_BOT;
				end
			end
			S_BOT: begin
				if (sts.z_le_h) begin
					cmd.res_ld  = 1'b1;
					cmd.res_pos = POS_BOT;
					state_nx    = S_FIN;
				end else begin
					cmd.srch_init = 1'b1;
					state_nx      = S_CHK;
				end
			end
			S_CHK: begin
				cmd.rd_en = 1'b1;
				if (sts.srch_done) begin
					cmd.rd_sel = RD_LO;
					state_nx   = S_LD0;
				end else begin
					cmd.rd_sel = RD_MID;
					state_nx   = S_CMP;
				end
			end
			S_CMP: begin
				cmd.srch_step = 1'b1;
				state_nx      = S_CHK;
			end
			S_LD0: begin
				cmd.ld_p0  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_LO1;
				state_nx   = S_LD1;
			end
			S_LD1: begin
				cmd.ld_p1 = 1'b1;
				state_nx  = S_DCHK;
			end
			S_DCHK: begin
				cmd.div_setup = 1'b1;
				// fraction known without dividing: zero, or saturated
				if (sts.frac_zero || sts.frac_sat)
					state_nx = S_MUL;
				else
					state_nx = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DCNT_W'(FRAC_W - 1))
					state_nx = S_MUL;
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = S_RND;
			end
			S_RND: begin
				cmd.rnd  = 1'b1;
				state_nx = S_ADD;
			end
			S_ADD: begin
				cmd.res_ld  = 1'b1;
				cmd.res_pos = POS_IN;
				state_nx    = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_ld = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.div_setup)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + DCNT_W'(1);
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule
